FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the scheduler RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define ASSERT_CLK(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(name, clk, rst, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

FILE: rtl/ppsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppsa_pkg
// Types and constants of the preemptive priority scheduler with aging.
// ----------------------------------------------------------------------------
package ppsa_pkg;

  localparam int NUM_TASKS = 16;
  localparam int IDX_W     = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

  localparam int SLOT_W = 4;
  localparam int ARR_W  = 10;
  localparam int SVC_W  = 8;
  localparam int PRIO_W = 4;
  localparam int WAIT_W = 3;
  localparam int TIME_W = 16;

  localparam int IN_BITS     = SLOT_W + ARR_W + SVC_W + PRIO_W;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_BITS    = TIME_W + 1 + SLOT_W + 3;
  localparam int OUT_TDATA_W = 24;

  localparam logic [ARR_W-1:0]  STOP_TIME_RESET = ARR_W'(100);
  localparam logic [WAIT_W-1:0] WAIT_MAX        = WAIT_W'(7);
  localparam logic [WAIT_W-1:0] AGE_LIMIT       = WAIT_W'(5);
  localparam logic [PRIO_W-1:0] PRIO_FLOOR      = PRIO_W'(1);
  localparam logic [SVC_W-1:0]  LAST_QUANTUM    = SVC_W'(1);

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // Load item payload, slot in the lowest bits
  typedef struct packed {
    logic [PRIO_W-1:0] priority_req;
    logic [SVC_W-1:0]  service_time;
    logic [ARR_W-1:0]  arrival;
    logic [SLOT_W-1:0] slot;
  } task_load_t;

  // Tick result, time_slot in the lowest bits
  typedef struct packed {
    logic              finished;
    logic              completed_now;
    logic              started_now;
    logic [SLOT_W-1:0] run_slot;
    logic              ran;
    logic [TIME_W-1:0] time_slot;
  } tick_result_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic tick_start;
    logic scan;
    logic commit;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic scan_last;
    logic out_free;
  } dp_status_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_FINAL = 3'b100
  } state_t;

endpackage

FILE: rtl/ppsa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppsa_ctrl
// Sequencer: accepts items, walks the slot scan and commits each tick.
// ----------------------------------------------------------------------------
module ppsa_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_mode,
  output logic                  in_ready,
  output ppsa_pkg::ctrl_cmd_t   cmd,
  input  ppsa_pkg::dp_status_t  status
);

  ppsa_pkg::state_t state, state_next;

  // Take items only between ticks, never in reset
  assign in_ready = !rst && (state == ppsa_pkg::ST_IDLE);

  // Decode commands
  always_comb begin
    cmd            = '0;
    cmd.load       = in_ready && in_valid && (in_mode == ppsa_pkg::MODE_LOAD);
    cmd.tick_start = in_ready && in_valid && (in_mode == ppsa_pkg::MODE_TICK);
    cmd.scan       = (state == ppsa_pkg::ST_SCAN);
    cmd.commit     = (state == ppsa_pkg::ST_FINAL) && status.out_free;
  end

  // Advance the sequence
  always_comb begin
    state_next = state;
    unique case (state)
      ppsa_pkg::ST_IDLE: begin
        if (cmd.tick_start) state_next = ppsa_pkg::ST_SCAN;
      end
      ppsa_pkg::ST_SCAN: begin
        if (status.scan_last) state_next = ppsa_pkg::ST_FINAL;
      end
      ppsa_pkg::ST_FINAL: begin
        if (status.out_free) state_next = ppsa_pkg::ST_IDLE;
      end
      default: state_next = ppsa_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ppsa_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: rtl/ppsa_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppsa_dp
// Task tables, one-slot-per-cycle aging and selection, tick commit, result
// register and the stop time register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ppsa_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  ppsa_pkg::ctrl_cmd_t                cmd,
  output ppsa_pkg::dp_status_t               status,
  input  ppsa_pkg::task_load_t               load,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ppsa_pkg::ARR_W-1:0]         cfg_data,
  output ppsa_pkg::tick_result_t             res,
  output logic                               out_valid,
  input  logic                               out_ready
);

  localparam int N  = ppsa_pkg::NUM_TASKS;
  localparam int IW = ppsa_pkg::IDX_W;

  // Per-slot state
  logic [N-1:0]                  loaded, done, started;
  logic [ppsa_pkg::ARR_W-1:0]    arr_tab  [N];
  logic [ppsa_pkg::PRIO_W-1:0]   prio_tab [N];
  logic [ppsa_pkg::SVC_W-1:0]    rem_tab  [N];
  logic [ppsa_pkg::WAIT_W-1:0]   wait_tab [N];

  // Global state
  logic [ppsa_pkg::TIME_W-1:0]   cur_time;
  logic [IW-1:0]                 last_slot;
  logic                          last_valid;
  logic                          sim_fin;
  logic [ppsa_pkg::ARR_W-1:0]    stop_time;

  // Tick working registers
  logic [IW-1:0]                 idx;
  logic [IW-1:0]                 best_idx;
  logic                          best_found;
  logic [ppsa_pkg::PRIO_W-1:0]   best_prio;
  logic [ppsa_pkg::ARR_W-1:0]    best_arr;
  logic                          age_en;
  logic                          tick_stop;
  logic                          past_end;

  ppsa_pkg::tick_result_t        res_q, res_next;

  // Load decode
  logic [IW-1:0] ld_idx;
  logic          ld_ok;
  assign ld_idx = IW'(load.slot);
  assign ld_ok  = (int'(load.slot) < N);

  // Examine the slot under the scan index
  logic                          slot_ready, slot_skip, better;
  logic [ppsa_pkg::WAIT_W-1:0]   w_inc, aged_w;
  logic [ppsa_pkg::PRIO_W-1:0]   aged_pr;
  logic [N-1:0]                  pending;

  assign pending    = loaded & ~done;
  assign slot_ready = loaded[idx] && !done[idx] &&
                      (ppsa_pkg::TIME_W'(arr_tab[idx]) <= cur_time);
  assign slot_skip  = last_valid && (last_slot == idx);
  assign w_inc      = (wait_tab[idx] < ppsa_pkg::WAIT_MAX) ?
                      wait_tab[idx] + ppsa_pkg::WAIT_W'(1) : wait_tab[idx];

  always_comb begin
    aged_pr = prio_tab[idx];
    aged_w  = wait_tab[idx];
    if (age_en && slot_ready && !slot_skip) begin
      if (w_inc >= ppsa_pkg::AGE_LIMIT && prio_tab[idx] > ppsa_pkg::PRIO_FLOOR) begin
        aged_pr = prio_tab[idx] - ppsa_pkg::PRIO_W'(1);
        aged_w  = '0;
      end else begin
        aged_w  = w_inc;
      end
    end
  end

  // Strict compare keeps the lower slot on a full tie
  assign better = slot_ready &&
                  (!best_found || aged_pr < best_prio ||
                   (aged_pr == best_prio && arr_tab[idx] < best_arr));

  // Tick outcome, idx holds the chosen slot at this point
  logic         do_run, do_adv, do_fin, comp, first;
  logic [N-1:0] pend_after;

  assign comp       = (rem_tab[idx] <= ppsa_pkg::LAST_QUANTUM);
  assign first      = !started[idx];
  assign pend_after = pending & ~(N'(1) << idx);

  always_comb begin
    do_run   = 1'b0;
    do_adv   = 1'b0;
    do_fin   = 1'b0;
    res_next = '0;
    res_next.time_slot = cur_time;
    priority if (tick_stop) begin
      do_fin = 1'b1;
    end else if (!best_found && past_end) begin
      do_fin = 1'b1;
    end else if (!best_found) begin
      do_adv = 1'b1;
    end else if (past_end && !started[idx]) begin
      do_fin = 1'b1;
    end else begin
      do_run = 1'b1;
      do_adv = 1'b1;
      do_fin = comp && (pend_after == '0);
    end
    res_next.finished = do_fin;
    if (do_run) begin
      res_next.ran           = 1'b1;
      res_next.run_slot      = ppsa_pkg::SLOT_W'(idx);
      res_next.started_now   = first;
      res_next.completed_now = comp;
    end
  end

  // Status to the controller
  assign status.scan_last = (idx == IW'(N - 1));
  assign status.out_free  = !out_valid || out_ready;

  assign cfg_ready = !rst;
  assign res       = res_q;

  // Control state and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      loaded     <= '0;
      done       <= '0;
      started    <= '0;
      for (int i = 0; i < N; i++) wait_tab[i] <= '0;
      cur_time   <= '0;
      last_slot  <= '0;
      last_valid <= 1'b0;
      sim_fin    <= 1'b0;
      stop_time  <= ppsa_pkg::STOP_TIME_RESET;
      idx        <= '0;
      best_idx   <= '0;
      best_found <= 1'b0;
      age_en     <= 1'b0;
      tick_stop  <= 1'b0;
      past_end   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid) stop_time <= cfg_data;

      // Load a slot
      if (cmd.load && ld_ok) begin
        loaded[ld_idx]   <= 1'b1;
        done[ld_idx]     <= 1'b0;
        started[ld_idx]  <= 1'b0;
        wait_tab[ld_idx] <= '0;
        if (last_valid && last_slot == ld_idx) last_valid <= 1'b0;
      end

      // Latch the tick conditions and rewind the scan
      if (cmd.tick_start) begin
        idx        <= '0;
        best_found <= 1'b0;
        tick_stop  <= sim_fin || (pending == '0);
        age_en     <= !sim_fin && (pending != '0) &&
                      (cur_time < ppsa_pkg::TIME_W'(stop_time));
        past_end   <= !(cur_time < ppsa_pkg::TIME_W'(stop_time));
      end

      // Age one slot and track the best candidate
      if (cmd.scan) begin
        wait_tab[idx] <= aged_w;
        if (better) begin
          best_found <= 1'b1;
          best_idx   <= idx;
        end
        if (status.scan_last) begin
          idx <= better ? idx : best_idx;
        end else begin
          idx <= idx + IW'(1);
        end
      end

      // Commit the tick
      if (cmd.commit) begin
        if (do_fin) sim_fin <= 1'b1;
        if (do_adv) cur_time <= cur_time + ppsa_pkg::TIME_W'(1);
        if (do_run) begin
          last_slot    <= idx;
          last_valid   <= 1'b1;
          started[idx] <= 1'b1;
          if (comp) done[idx] <= 1'b1;
        end
      end

      // Hold the result until taken
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load && ld_ok) begin
      arr_tab[ld_idx]  <= load.arrival;
      rem_tab[ld_idx]  <= load.service_time;
      prio_tab[ld_idx] <= load.priority_req;
    end
    if (cmd.scan) begin
      prio_tab[idx] <= aged_pr;
      if (better) begin
        best_prio <= aged_pr;
        best_arr  <= arr_tab[idx];
      end
    end
    if (cmd.commit && do_run) begin
      rem_tab[idx] <= comp ? '0 : rem_tab[idx] - ppsa_pkg::SVC_W'(1);
    end
    if (cmd.commit) res_q <= res_next;
  end

  // Checks
  `ASSERT_CLK(a_run_ready, clk, rst,
    (cmd.commit && do_run) |-> (loaded[idx] && !done[idx]), "ran a slot that was not ready")
  `ASSERT_CLK(a_fin_sticky, clk, rst, sim_fin |=> sim_fin, "finished flag cleared")
  `ASSERT_CLK(a_time_commit, clk, rst, !cmd.commit |=> $stable(cur_time),
    "time moved outside a commit")
  `ASSERT_CLK(a_out_source, clk, rst, $rose(out_valid) |-> $past(cmd.commit),
    "result appeared without a commit")

endmodule

FILE: rtl/preemptive_priority_scheduler_aging.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_aging
// Highest-priority-first preemptive scheduler with aging, one quantum a tick.
// ----------------------------------------------------------------------------
//  channel   | direction | tdata / data                        | tuser
//  s_axis    | in        | slot, arrival, service, priority    | mode
//  m_axis    | out       | time, ran, slot, started, done, fin | -
//  cfg       | in        | stop time                           | -
//
//  A load item is taken while the block is idle. A tick item is accepted,
//  then each task slot in turn passes through the shared aging and compare
//  step, and then the tick commits.
//  Reset is synchronous and ready at once; there is no clearing pass.
//  The commit waits while an earlier result is still held on m_axis.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler_aging (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [3:0] slot, [13:4] arrival, [21:14] service_time,
  // [25:22] priority_req, [31:26] zero
  input  logic [ppsa_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // [0] mode
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [15:0] time_slot, [16] ran, [20:17] run_slot, [21] started_now,
  // [22] completed_now, [23] finished
  output logic [ppsa_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ppsa_pkg::ARR_W-1:0]        cfg_data
);

  ppsa_pkg::ctrl_cmd_t    cmd;
  ppsa_pkg::dp_status_t   status;
  ppsa_pkg::task_load_t   load;
  ppsa_pkg::tick_result_t res;

  assign load         = ppsa_pkg::task_load_t'(s_axis_tdata[ppsa_pkg::IN_BITS-1:0]);
  assign m_axis_tdata = ppsa_pkg::OUT_TDATA_W'(res);

  ppsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_mode  (s_axis_tuser),
    .in_ready (s_axis_tready),
    .cmd      (cmd),
    .status   (status)
  );

  ppsa_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .load      (load),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .res       (res),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready)
  );

endmodule

FILE: tb/sv/preemptive_priority_scheduler_aging_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_aging_tb
// Self-checking bench for the aging priority scheduler.
// Drives task loads and quantum ticks on the input stream and keeps its own
// copy of the task tables. Each tick item is run through that copy, and every
// tick result on the output stream is compared field by field, in order.
// The run steps the stop time through its reset value, the maximum, a value
// just ahead of the current quantum and zero, with random idle bursts on both
// streams except in the last phase.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler_aging_tb;

  // cycles to let a load settle before a register write, and at the end
  localparam int SETTLE_CYCLES = 40;
  // cycles with no handshake on any channel before the run is abandoned
  localparam int QUIET_LIMIT   = 1000;

  logic                             clk;
  logic                             rst;
  logic                             s_axis_tvalid;
  logic                             s_axis_tready;
  logic [ppsa_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
  logic                             s_axis_tuser;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready;
  logic [ppsa_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic                             cfg_valid;
  logic                             cfg_ready;
  logic [ppsa_pkg::ARR_W-1:0]       cfg_data;

  // Task tables and quantum clock mirrored from the scheduler
  class quantum_scoreboard;
    bit                         loaded    [ppsa_pkg::NUM_TASKS];
    bit [ppsa_pkg::ARR_W-1:0]   arrival   [ppsa_pkg::NUM_TASKS];
    bit [ppsa_pkg::PRIO_W-1:0]  prio      [ppsa_pkg::NUM_TASKS];
    bit [ppsa_pkg::SVC_W-1:0]   remaining [ppsa_pkg::NUM_TASKS];
    bit [ppsa_pkg::WAIT_W-1:0]  waits     [ppsa_pkg::NUM_TASKS];
    bit                         done      [ppsa_pkg::NUM_TASKS];
    bit                         started   [ppsa_pkg::NUM_TASKS];
    bit [ppsa_pkg::TIME_W-1:0]  now;
    bit [ppsa_pkg::SLOT_W-1:0]  last_slot;
    bit                         last_valid;
    bit                         halted;
    bit [ppsa_pkg::ARR_W-1:0]   stop_time;
    ppsa_pkg::tick_result_t     pending_quanta[$];
    int                         errors;

    function new();
      stop_time = ppsa_pkg::STOP_TIME_RESET;
    endfunction

    function bit all_done();
      foreach (loaded[i])
        if (loaded[i] && !done[i])
          return 1'b0;
      return 1'b1;
    endfunction

    function bit ready(int i);
      return loaded[i] && !done[i] && (ppsa_pkg::TIME_W'(arrival[i]) <= now);
    endfunction

    // Fill one slot; a reload of the last runner forgets that it ran
    function void load_slot(ppsa_pkg::task_load_t ld);
      int s;
      s = int'(ld.slot);
      loaded[s]    = 1'b1;
      arrival[s]   = ld.arrival;
      remaining[s] = ld.service_time;
      prio[s]      = ld.priority_req;
      waits[s]     = '0;
      done[s]      = 1'b0;
      started[s]   = 1'b0;
      if (last_valid && last_slot == s)
        last_valid = 1'b0;
    endfunction

    // Age, select and run one quantum
    function ppsa_pkg::tick_result_t run_quantum();
      ppsa_pkg::tick_result_t r;
      int                     best;
      bit                     comp;
      r           = '0;
      r.time_slot = now;
      best        = -1;

      if (halted || all_done()) begin
        halted     = 1'b1;
        r.finished = 1'b1;
        return r;
      end

      // age every waiting task while before the stop time
      if (now < stop_time) begin
        for (int i = 0; i < ppsa_pkg::NUM_TASKS; i++) begin
          if (!ready(i) || (last_valid && last_slot == i))
            continue;
          if (waits[i] < ppsa_pkg::WAIT_MAX)
            waits[i]++;
          if (waits[i] >= ppsa_pkg::AGE_LIMIT && prio[i] > ppsa_pkg::PRIO_FLOOR) begin
            prio[i]--;
            waits[i] = '0;
          end
        end
      end

      // lowest priority value, then earliest arrival, then lowest slot
      for (int i = 0; i < ppsa_pkg::NUM_TASKS; i++) begin
        if (!ready(i))
          continue;
        if (best < 0 || prio[i] < prio[best] ||
            (prio[i] == prio[best] && arrival[i] < arrival[best]))
          best = i;
      end

      if (best < 0) begin
        if (now >= stop_time) begin
          halted     = 1'b1;
          r.finished = 1'b1;
          return r;
        end
        now++;
        return r;
      end

      if (now >= stop_time && !started[best]) begin
        halted     = 1'b1;
        r.finished = 1'b1;
        return r;
      end

      last_slot     = ppsa_pkg::SLOT_W'(best);
      last_valid    = 1'b1;
      r.ran         = 1'b1;
      r.run_slot    = ppsa_pkg::SLOT_W'(best);
      r.started_now = !started[best];
      started[best] = 1'b1;
      comp          = remaining[best] <= ppsa_pkg::LAST_QUANTUM;
      if (comp) begin
        remaining[best] = '0;
        done[best]      = 1'b1;
      end else begin
        remaining[best]--;
      end
      if (comp && all_done())
        halted = 1'b1;
      r.completed_now = comp;
      r.finished      = halted;
      now++;
      return r;
    endfunction

    function void note_item(logic mode, ppsa_pkg::task_load_t ld);
      if (mode == ppsa_pkg::MODE_LOAD)
        load_slot(ld);
      else
        pending_quanta.push_back(run_quantum());
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    task check_quantum(ppsa_pkg::tick_result_t got);
      ppsa_pkg::tick_result_t want;
      if (pending_quanta.size() == 0) begin
        report($sformatf("unexpected result %h", got));
        return;
      end
      want = pending_quanta.pop_front();
      if (got.time_slot != want.time_slot)
        report($sformatf("time_slot %0d, want %0d", got.time_slot, want.time_slot));
      if (got.ran != want.ran)
        report($sformatf("q%0d ran %0d, want %0d", want.time_slot, got.ran, want.ran));
      if (got.run_slot != want.run_slot)
        report($sformatf("q%0d run_slot %0d, want %0d", want.time_slot, got.run_slot,
                         want.run_slot));
      if (got.started_now != want.started_now)
        report($sformatf("q%0d started_now %0d, want %0d", want.time_slot,
                         got.started_now, want.started_now));
      if (got.completed_now != want.completed_now)
        report($sformatf("q%0d completed_now %0d, want %0d", want.time_slot,
                         got.completed_now, want.completed_now));
      if (got.finished != want.finished)
        report($sformatf("q%0d finished %0d, want %0d", want.time_slot, got.finished,
                         want.finished));
    endtask
  endclass

  quantum_scoreboard sb;
  bit                bursts_on;
  int                quiet_cycles;

  preemptive_priority_scheduler_aging uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Drive the result side ready, with random stall bursts
  initial begin : result_ready
    int hold;
    hold          = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold == 0 && bursts_on && $urandom_range(0, 5) == 0)
        hold = $urandom_range(1, 7);
      if (hold > 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Check results and watch for a hang
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready)
        sb.check_quantum(ppsa_pkg::tick_result_t'(m_axis_tdata));
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no progress, %0d results outstanding",
                 sb.pending_quanta.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Present one item, with an optional idle burst first, and hold it until taken
  task automatic send_item(logic mode, ppsa_pkg::task_load_t ld);
    int gap;
    @(negedge clk);
    if (bursts_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 7);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ppsa_pkg::IN_TDATA_W'(ld);
    s_axis_tuser  <= mode;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_item(mode, ld);
  endtask

  task automatic load_task(int slot, int arr, int svc, int pri);
    ppsa_pkg::task_load_t ld;
    ld.slot         = ppsa_pkg::SLOT_W'(slot);
    ld.arrival      = ppsa_pkg::ARR_W'(arr);
    ld.service_time = ppsa_pkg::SVC_W'(svc);
    ld.priority_req = ppsa_pkg::PRIO_W'(pri);
    send_item(ppsa_pkg::MODE_LOAD, ld);
  endtask

  // Ticks carry random payload bits, which the block ignores
  task automatic tick_run(int n);
    bit [31:0] noise;
    repeat (n) begin
      noise = $urandom;
      send_item(ppsa_pkg::MODE_TICK,
                ppsa_pkg::task_load_t'(noise[ppsa_pkg::IN_BITS-1:0]));
    end
  endtask

  // Let the block go idle: no item pending, every result back, loads settled
  task automatic drain();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (sb.pending_quanta.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_stop_time(logic [ppsa_pkg::ARR_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.stop_time = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly ticks; loads land in slots below the top one, which holds a far
  // arrival task so the schedule does not run dry
  task automatic random_phase(int n);
    ppsa_pkg::task_load_t      ld;
    bit [ppsa_pkg::TIME_W-1:0] near;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) < 3) begin
        ld.slot = ppsa_pkg::SLOT_W'($urandom_range(0, ppsa_pkg::NUM_TASKS - 2));
        if ($urandom_range(0, 9) < 7) begin
          near       = ppsa_pkg::TIME_W'(sb.now + $urandom_range(0, 6));
          ld.arrival = (near >= (1 << ppsa_pkg::ARR_W)) ? '1 :
                       near[ppsa_pkg::ARR_W-1:0];
        end else begin
          ld.arrival = ppsa_pkg::ARR_W'($urandom_range(0, (1 << ppsa_pkg::ARR_W) - 1));
        end
        case ($urandom_range(0, 9))
          0:       ld.service_time = '0;
          1:       ld.service_time = ppsa_pkg::SVC_W'(
                     $urandom_range(0, (1 << ppsa_pkg::SVC_W) - 1));
          default: ld.service_time = ppsa_pkg::SVC_W'($urandom_range(1, 6));
        endcase
        ld.priority_req = ppsa_pkg::PRIO_W'(
                            $urandom_range(0, (1 << ppsa_pkg::PRIO_W) - 1));
        send_item(ppsa_pkg::MODE_LOAD, ld);
      end else begin
        tick_run(1);
      end
    end
  endtask

  initial begin
    bit [ppsa_pkg::TIME_W-1:0] ahead;
    sb            = new();
    bursts_on     = 1'b1;
    quiet_cycles  = 0;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = ppsa_pkg::MODE_LOAD;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed, under the reset stop time: zero service and priority zero,
    // preemption by an urgent arrival, reload of the running slot, a far
    // arrival with every field at its top, aging past a long runner, idle
    load_task(0, 0, 3, 15);
    load_task(15, 0, 0, 0);
    load_task(5, 4, 2, 1);
    tick_run(3);
    load_task(0, 0, 255, 15);
    tick_run(3);
    load_task(15, 1023, 255, 15);
    load_task(2, 6, 1, 15);
    tick_run(8);
    load_task(0, 30, 1, 3);
    tick_run(3);
    drain();

    // Random schedule with the latest stop time
    write_stop_time('1);
    random_phase(200);
    drain();

    // Stop time a little ahead: aging stops and the schedule winds down
    ahead = ppsa_pkg::TIME_W'(sb.now + 40);
    write_stop_time((ahead >= (1 << ppsa_pkg::ARR_W)) ? '1 :
                    ahead[ppsa_pkg::ARR_W-1:0]);
    random_phase(150);
    drain();

    // Stop time zero, full rate on both sides
    bursts_on = 1'b0;
    write_stop_time('0);
    random_phase(40);
    drain();

    if (sb.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/ppsa_pkg.sv
rtl/ppsa_ctrl.sv
rtl/ppsa_dp.sv
rtl/preemptive_priority_scheduler_aging.sv
tb/sv/preemptive_priority_scheduler_aging_tb.sv
